### design/wmpr_pkg.sv
// Package for the window median peak reporter.
// Word types, function codes, controller/datapath command and status structs.
// No dependencies.
package wmpr_pkg;

    // Default number of sample entries in the store
    localparam int DEPTH_DEFAULT = 64;

    // Reset value of the min_count register
    localparam logic [6:0] MIN_COUNT_RESET = 7'd10;

    // Function codes of the input word
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // Input word
    typedef struct packed {
        logic        func;
        logic [15:0] sample_value;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [15:0] median_value;
        logic [15:0] peak_value;
        logic        from_samples;
        logic [6:0]  sample_count;
    } out_word_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_sample;
        logic take_report;
        logic ins_read;
        logic ins_step;
        logic rep_lo;
        logic rep_hi;
        logic rep_sum;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic k_zero;
        logic shift_more;
        logic take_median;
        logic out_free;
    } status_t;

endpackage

### design/wmpr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wmpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/wmpr_ctrl.sv
// Controller of the window median peak reporter: sequences sample insertion
// and report reads. Uses wmpr_pkg for command and status structs.
module wmpr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_func,
    output logic              s_ready,
    input  wmpr_pkg::status_t status,
    output wmpr_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REP_LO,
        ST_REP_HI,
        ST_REP_SUM,
        ST_REP_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Decode commands and advance
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == wmpr_pkg::FUNC_REPORT) begin
                        cmd.take_report = 1'b1;
                        state_next = status.take_median ? ST_REP_LO : ST_REP_OUT;
                    end else begin
                        cmd.take_sample = 1'b1;
                        state_next = status.full ? ST_IDLE : ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                cmd.ins_read = 1'b1;
                state_next = status.k_zero ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP: begin
                cmd.ins_step = 1'b1;
                state_next = status.shift_more ? ST_INS_RD : ST_IDLE;
            end
            ST_REP_LO: begin
                cmd.rep_lo = 1'b1;
                state_next = ST_REP_HI;
            end
            ST_REP_HI: begin
                cmd.rep_hi = 1'b1;
                state_next = ST_REP_SUM;
            end
            ST_REP_SUM: begin
                cmd.rep_sum = 1'b1;
                state_next = ST_REP_OUT;
            end
            ST_REP_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/wmpr_dp.sv
// Datapath of the window median peak reporter: sorted sample store, counters,
// peak hold, median arithmetic and output register. Uses wmpr_pkg, wmpr_ram.
module wmpr_dp #(
    parameter int DEPTH = wmpr_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wmpr_pkg::in_word_t  s_word,
    input  logic                cfg_valid,
    input  logic [6:0]          cfg_data,
    input  wmpr_pkg::cmd_t      cmd,
    output wmpr_pkg::status_t   status,
    output wmpr_pkg::out_word_t m_word,
    output logic                m_valid,
    input  logic                m_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 7;

    logic [CW-1:0]       held_reg;
    logic [15:0]         peak_reg;
    logic [6:0]          min_count_reg;
    logic [15:0]         val_reg;
    logic [AW-1:0]       k_reg;
    logic [15:0]         a_reg;
    logic [15:0]         med_reg;
    logic                rep_from_reg;
    logic [15:0]         rep_peak_reg;
    logic [6:0]          rep_cnt_reg;
    wmpr_pkg::out_word_t m_word_reg;
    logic                m_valid_reg;

    logic [XW-1:0] held_x;
    logic [XW-1:0] min_x;
    logic [CW-1:0] held_m1;
    logic [AW-1:0] lo_addr;
    logic [AW-1:0] hi_addr;
    logic [16:0]   mid_sum;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    // Sorted sample store
    wmpr_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Count compare and middle addresses
    assign held_x  = XW'(held_reg);
    assign min_x   = XW'(min_count_reg);
    assign held_m1 = held_reg - 1'b1;
    assign lo_addr = AW'(held_m1 >> 1);
    assign hi_addr = AW'(held_reg >> 1);
    assign mid_sum = {1'b0, a_reg} + {1'b0, rd_data};

    assign status.full        = (held_reg == CW'(DEPTH));
    assign status.k_zero      = (k_reg == '0);
    assign status.shift_more  = (rd_data > val_reg);
    assign status.take_median = (held_x >= min_x) && (held_reg != '0);
    assign status.out_free    = !m_valid_reg || m_ready;

    // Store access: shift larger entries up one slot, then drop the new value in
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = k_reg;
        wr_data = val_reg;
        rd_en   = 1'b0;
        rd_addr = k_reg - 1'b1;
        if (cmd.ins_read) begin
            if (k_reg == '0) begin
                wr_en = 1'b1;
            end else begin
                rd_en = 1'b1;
            end
        end
        if (cmd.ins_step) begin
            wr_en = 1'b1;
            if (rd_data > val_reg) begin
                wr_data = rd_data;
            end
        end
        if (cmd.rep_lo) begin
            rd_en   = 1'b1;
            rd_addr = lo_addr;
        end
        if (cmd.rep_hi) begin
            rd_en   = 1'b1;
            rd_addr = hi_addr;
        end
    end

    // Control state: counters, peak, config, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            peak_reg      <= '0;
            min_count_reg <= wmpr_pkg::MIN_COUNT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                min_count_reg <= cfg_data;
            end
            if (cmd.take_sample && (s_word.sample_value > peak_reg)) begin
                peak_reg <= s_word.sample_value;
            end
            if (cmd.take_report) begin
                peak_reg <= '0;
            end
            if ((cmd.ins_read && (k_reg == '0)) || (cmd.ins_step && !(rd_data > val_reg))) begin
                held_reg <= held_reg + 1'b1;
            end
            if (cmd.rep_sum) begin
                held_reg <= '0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take_sample) begin
            val_reg <= s_word.sample_value;
            k_reg   <= AW'(held_reg);
        end
        if (cmd.ins_step) begin
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.take_report) begin
            med_reg      <= peak_reg;
            rep_peak_reg <= peak_reg;
            rep_from_reg <= status.take_median;
            rep_cnt_reg  <= held_x[6:0];
        end
        if (cmd.rep_hi) begin
            a_reg <= rd_data;
        end
        if (cmd.rep_sum) begin
            med_reg <= mid_sum[16:1];
        end
        if (cmd.out_load) begin
            m_word_reg.median_value <= med_reg;
            m_word_reg.peak_value   <= rep_peak_reg;
            m_word_reg.from_samples <= rep_from_reg;
            m_word_reg.sample_count <= rep_cnt_reg;
        end
    end

    assign m_word  = m_word_reg;
    assign m_valid = m_valid_reg;

endmodule

### design/window_median_peak_reporter.sv
// Top level of the window median peak reporter: controller plus datapath.
// Uses wmpr_pkg, wmpr_ctrl, wmpr_dp.
//
//   channel  ports                       word
//   input    s_valid s_ready s_word      func, sample_value
//   result   m_valid m_ready m_word      median_value, peak_value, from_samples,
//                                        sample_count
//   config   cfg_valid cfg_ready cfg_data  min_count
//
// Samples stay sorted by insertion into a one-write, one-read RAM: a stored
// sample moves each held sample larger than it up one slot, then is written
// in; a sample that arrives with the store full is dropped. A report reads
// the median (two RAM reads and an add) or lets the peak stand in, and may
// wait for the output register to free. Synchronous active-low reset empties
// the store (count only) and clears the peak; input is taken whenever idle.
module window_median_peak_reporter #(
    parameter int DEPTH = wmpr_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wmpr_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output wmpr_pkg::out_word_t m_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data
);

    wmpr_pkg::cmd_t    cmd;
    wmpr_pkg::status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    wmpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_word.func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wmpr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_word    (s_word),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_word    (m_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule

### verif/window_median_peak_reporter_checker.sv
// Checker for the window median peak reporter: watches the input, result and
// config channels, predicts each report word and compares it field by field.
// Depends on wmpr_pkg.
`timescale 1ns / 100ps

module window_median_peak_reporter_checker import wmpr_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_word,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_word,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [6:0] cfg_data,
    output int        errors,
    output int        pending
);

    // Shadow copy of the block state
    logic [15:0] held [DEPTH];
    int unsigned n_held;
    logic [15:0] peak_run;
    logic [6:0]  min_needed;
    out_word_t   reports_due [$];

    // Median of the held samples: sort a copy, take the middle or the mean of two
    function automatic logic [15:0] median_of_held();
        logic [15:0] srt [DEPTH];
        logic [15:0] v;
        logic [16:0] sum;
        int k;
        for (int i = 0; i < n_held; i++) srt[i] = held[i];
        for (int i = 1; i < n_held; i++) begin
            v = srt[i];
            k = i;
            while (k > 0 && srt[k-1] > v) begin
                srt[k] = srt[k-1];
                k--;
            end
            srt[k] = v;
        end
        if (n_held % 2 == 1) return srt[n_held / 2];
        sum = {1'b0, srt[n_held/2 - 1]} + {1'b0, srt[n_held/2]};
        return sum[16:1];
    endfunction

    // Sample all three channels at the clock edge
    always @(posedge aclk) begin : watch
        out_word_t want;
        if (!aresetn) begin
            n_held     = 0;
            peak_run   = '0;
            min_needed = MIN_COUNT_RESET;
            errors     = 0;
            reports_due.delete();
        end else begin
            // Register write
            if (cfg_valid && cfg_ready) min_needed = cfg_data;

            // Accepted input word: store or drop a sample, or build a report
            if (s_valid && s_ready) begin
                if (s_word.func == FUNC_SAMPLE) begin
                    if (n_held < DEPTH) begin
                        held[n_held] = s_word.sample_value;
                        n_held++;
                    end
                    if (s_word.sample_value > peak_run) peak_run = s_word.sample_value;
                end else begin
                    want.sample_count = 7'(n_held);
                    want.peak_value   = peak_run;
                    if (n_held >= min_needed && n_held > 0) begin
                        want.median_value = median_of_held();
                        want.from_samples = 1'b1;
                        n_held = 0;
                    end else begin
                        want.median_value = peak_run;
                        want.from_samples = 1'b0;
                    end
                    reports_due.insert(reports_due.size(), want);
                    peak_run = '0;
                end
            end

            // Accepted result word: compare with the oldest prediction
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("unexpected result word %h", m_word);
                    errors++;
                end else begin
                    want = reports_due.pop_front();
                    if (m_word.median_value !== want.median_value) begin
                        $error("median_value: expected %0d, got %0d",
                               want.median_value, m_word.median_value);
                        errors++;
                    end
                    if (m_word.peak_value !== want.peak_value) begin
                        $error("peak_value: expected %0d, got %0d",
                               want.peak_value, m_word.peak_value);
                        errors++;
                    end
                    if (m_word.from_samples !== want.from_samples) begin
                        $error("from_samples: expected %0d, got %0d",
                               want.from_samples, m_word.from_samples);
                        errors++;
                    end
                    if (m_word.sample_count !== want.sample_count) begin
                        $error("sample_count: expected %0d, got %0d",
                               want.sample_count, m_word.sample_count);
                        errors++;
                    end
                end
            end
        end
        pending = reports_due.size();
    end

endmodule

### verif/window_median_peak_reporter_tb.sv
// Testbench top for the window median peak reporter: clock, reset, stimulus,
// back-pressure, watchdog and verdict. Depends on wmpr_pkg, the block and
// window_median_peak_reporter_checker.
`timescale 1ns / 100ps

module window_median_peak_reporter_tb;
    import wmpr_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int IDLE_PCT    = 29;
    localparam int PHASE_ITEMS = 100;
    // Covers the longest insert, which shifts every held sample, with margin on top
    localparam int SETTLE      = 2 * DEPTH + 40;
    localparam int QUIET_LIMIT = 20000;

    typedef enum int {VAL_FULL, VAL_DUPES, VAL_EDGES, VAL_HIGH} val_mode_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_word_t   s_word    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_word_t  m_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data  = '0;
    logic       calm      = 1'b0;

    int errors;
    int pending;
    int n_sent    = 0;
    int n_reports = 0;
    int n_phases  = 0;
    int quiet     = 0;

    window_median_peak_reporter #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    window_median_peak_reporter_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random stalls on the result side, none during a calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_value(input val_mode_t mode);
        case (mode)
            VAL_DUPES: return 16'($urandom_range(15));
            VAL_EDGES: return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
            VAL_HIGH:  return 16'($urandom_range(16'hFFFF, 16'hFFC0));
            default:   return 16'($urandom);
        endcase
    endfunction

    // Present one word, with random idle cycles ahead of it, and hold until taken
    task automatic send_word(input logic func, input logic [15:0] val);
        logic took;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= {func, val};
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        n_sent++;
        if (func == FUNC_REPORT) n_reports++;
    endtask

    // Drop valid and wait until every report is back, then let the block settle
    task automatic hold_until_drained(input int settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_min_count(input logic [6:0] val);
        logic took;
        hold_until_drained(SETTLE);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        cfg_valid <= 1'b0;
    endtask

    // One threshold setting: mostly sample bursts sized around the threshold
    // closed by a report, some overflowing the store, plus stray words
    task automatic run_phase(input logic [6:0] mc, input logic no_idle);
        int sent_here;
        int k;
        int lo;
        int hi;
        val_mode_t mode;
        write_min_count(mc);
        calm <= no_idle;
        n_phases++;
        sent_here = 0;
        while (sent_here < PHASE_ITEMS) begin
            mode = val_mode_t'($urandom_range(3));
            if ($urandom_range(4) == 0) begin
                send_word(1'($urandom_range(1)), pick_value(mode));
                sent_here++;
            end else begin
                hi = int'(mc) + 2;
                if (hi > DEPTH + 6) hi = DEPTH + 6;
                lo = int'(mc) - 2;
                if (lo < 0) lo = 0;
                if (lo > hi) lo = hi;
                case ($urandom_range(7))
                    0:       k = DEPTH + $urandom_range(6);
                    1:       k = $urandom_range(3);
                    default: k = $urandom_range(hi, lo);
                endcase
                for (int j = 0; j < k; j++) send_word(FUNC_SAMPLE, pick_value(mode));
                // Now and then stop feeding until all reports are out
                if ($urandom_range(15) == 0) hold_until_drained(0);
                send_word(FUNC_REPORT, 16'($urandom));
                sent_here += k + 1;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset threshold: empty report, then too few samples keeps the store
        send_word(FUNC_REPORT, 16'hFFFF);
        send_word(FUNC_SAMPLE, 16'h0000);
        send_word(FUNC_SAMPLE, 16'hFFFF);
        send_word(FUNC_SAMPLE, 16'h5555);
        send_word(FUNC_SAMPLE, 16'hAAAA);
        send_word(FUNC_REPORT, 16'h0000);

        // Threshold of one: even count of kept samples, then carry out of the sum, then an odd count
        write_min_count(7'd1);
        send_word(FUNC_REPORT, 16'h1234);
        send_word(FUNC_SAMPLE, 16'hFFFF);
        send_word(FUNC_SAMPLE, 16'hFFFE);
        send_word(FUNC_REPORT, 16'h0000);
        send_word(FUNC_SAMPLE, 16'd7);
        send_word(FUNC_SAMPLE, 16'd3);
        send_word(FUNC_SAMPLE, 16'd5);
        send_word(FUNC_REPORT, 16'h0000);

        // Zero threshold: empty store still substitutes the peak
        write_min_count(7'd0);
        send_word(FUNC_REPORT, 16'h0000);
        send_word(FUNC_SAMPLE, 16'd9);
        send_word(FUNC_REPORT, 16'h0000);

        // Random phases; thresholds at, above and far above the store depth
        // exercise overflow and permanent peak substitution
        run_phase(7'd3, 1'b0);
        run_phase(7'd64, 1'b0);
        run_phase(7'd127, 1'b1);
        run_phase(7'd1, 1'b0);
        run_phase(7'd65, 1'b0);
        run_phase(7'd10, 1'b0);
        run_phase(7'd16, 1'b0);
        run_phase(7'($urandom_range(64, 1)), 1'b0);
        run_phase(7'd2, 1'b0);

        hold_until_drained(SETTLE);
        $display("Sent %0d words (%0d reports) over %0d random threshold settings,",
                 n_sent, n_reports, n_phases);
        $display("including empty, full and overflowing stores and zero or oversized thresholds.");
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### window_median_peak_reporter.f
design/wmpr_pkg.sv
design/wmpr_ram.sv
design/wmpr_ctrl.sv
design/wmpr_dp.sv
design/window_median_peak_reporter.sv
verif/window_median_peak_reporter_checker.sv
verif/window_median_peak_reporter_tb.sv
